### rtl/rv32x_pkg.sv
// ----------------------------------------------------------------------------
// rv32x_pkg
// Shared constants, opcode codes and interface types of the RV32I subset
// execute unit.
// ----------------------------------------------------------------------------
package rv32x_pkg;

    localparam int XLEN           = 32;
    localparam int RF_DEPTH       = 32;
    localparam int RF_AW          = 5;
    localparam int DMEM_WORDS_DEF = 1024;

    // Major opcodes
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_JALR = 3'd0;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // Outcome of executing one instruction word
    typedef struct packed {
        logic            known;
        logic            wr;
        logic            mw;
        logic            load;
        logic [RF_AW-1:0] rd;
        logic [XLEN-1:0] val;
        logic [XLEN-1:0] addr;
        logic [XLEN-1:0] npc;
    } t_exec_res;

    // A register file write, pending or completed
    typedef struct packed {
        logic             v;
        logic [RF_AW-1:0] addr;
        logic [XLEN-1:0]  data;
    } t_rf_wr;

endpackage

### rtl/rv32x_ram.sv
// ----------------------------------------------------------------------------
// rv32x_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module rv32x_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rv32x_regfile.sv
// ----------------------------------------------------------------------------
// rv32x_regfile
// Register file: two RAM copies for the two source reads, per-entry valid
// bits for the zero reset, and forwarding of the pending and the last write.
// ----------------------------------------------------------------------------
module rv32x_regfile import rv32x_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_re,
    input  logic [RF_AW-1:0] i_raddr_a,
    input  logic [RF_AW-1:0] i_raddr_b,
    input  t_rf_wr           i_wr,
    input  t_rf_wr           i_pend,
    output logic [XLEN-1:0]  o_rdata_a,
    output logic [XLEN-1:0]  o_rdata_b
);

    logic [RF_AW-1:0]    r_ra_a;
    logic [RF_AW-1:0]    r_ra_b;
    logic [RF_DEPTH-1:0] r_valid;
    t_rf_wr              r_last;
    logic [XLEN-1:0]     ram_a;
    logic [XLEN-1:0]     ram_b;

    rv32x_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (i_wr.v),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_re),
        .i_raddr (i_raddr_a),
        .o_rdata (ram_a)
    );

    rv32x_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (i_wr.v),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_re),
        .i_raddr (i_raddr_b),
        .o_rdata (ram_b)
    );

    // The pending write is the youngest, then the last completed write, then
    // whatever the bank returned. An entry never written is zero.
    function automatic logic [XLEN-1:0] pick(
        input logic [RF_AW-1:0] ra,
        input logic [XLEN-1:0]  ram,
        input t_rf_wr           pend,
        input t_rf_wr           last,
        input logic [RF_DEPTH-1:0] valid
    );
        logic [XLEN-1:0] res;
        if (pend.v && pend.addr == ra) begin
            res = pend.data;
        end else if (last.v && last.addr == ra) begin
            res = last.data;
        end else if (valid[ra]) begin
            res = ram;
        end else begin
            res = '0;
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_last  <= '0;
        end else begin
            if (i_wr.v) begin
                r_valid[i_wr.addr] <= 1'b1;
                r_last             <= i_wr;
            end
        end
        if (i_re) begin
            r_ra_a <= i_raddr_a;
            r_ra_b <= i_raddr_b;
        end
    end

    assign o_rdata_a = pick(r_ra_a, ram_a, i_pend, r_last, r_valid);
    assign o_rdata_b = pick(r_ra_b, ram_b, i_pend, r_last, r_valid);

endmodule

### rtl/rv32x_exec.sv
// ----------------------------------------------------------------------------
// rv32x_exec
// Decode and execute of one instruction word: ALU result, branch and jump
// target, effective address and the flags of the result.
// ----------------------------------------------------------------------------
module rv32x_exec import rv32x_pkg::*; (
    input  logic [XLEN-1:0] i_instr,
    input  logic [XLEN-1:0] i_pc,
    input  logic [XLEN-1:0] i_a,
    input  logic [XLEN-1:0] i_b,
    output t_exec_res       o_res
);

    logic [6:0]       op;
    logic [2:0]       f3;
    logic [6:0]       f7;
    logic [RF_AW-1:0] rd;
    logic [4:0]       shamt_i;
    logic [4:0]       shamt_r;
    logic [XLEN-1:0]  imm_i;
    logic [XLEN-1:0]  imm_s;
    logic [XLEN-1:0]  imm_b;
    logic [XLEN-1:0]  imm_u;
    logic [XLEN-1:0]  imm_j;
    logic [XLEN-1:0]  pc_inc;
    logic             known;
    logic             wr;
    logic             mw;
    logic             load;
    logic             take;
    logic [XLEN-1:0]  val;
    logic [XLEN-1:0]  addr;
    logic [XLEN-1:0]  npc;

    assign op      = i_instr[6:0];
    assign rd      = i_instr[11:7];
    assign f3      = i_instr[14:12];
    assign f7      = i_instr[31:25];
    assign shamt_i = i_instr[24:20];
    assign shamt_r = i_b[4:0];
    assign imm_i   = {{20{i_instr[31]}}, i_instr[31:20]};
    assign imm_s   = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign imm_b   = {{19{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                      i_instr[11:8], 1'b0};
    assign imm_u   = {i_instr[31:12], 12'b0};
    assign imm_j   = {{11{i_instr[31]}}, i_instr[31], i_instr[19:12], i_instr[20],
                      i_instr[30:21], 1'b0};
    assign pc_inc  = i_pc + XLEN'(4);

    always_comb begin
        known = 1'b1;
        wr    = 1'b0;
        mw    = 1'b0;
        load  = 1'b0;
        take  = 1'b0;
        val   = '0;
        addr  = '0;
        npc   = pc_inc;
        unique case (op)
            OP_REG: begin
                wr = 1'b1;
                if (f7 == F7_BASE) begin
                    unique case (f3)
                        F3_ADD:  val = i_a + i_b;
                        F3_SLL:  val = i_a << shamt_r;
                        F3_SLT:  val = XLEN'($signed(i_a) < $signed(i_b));
                        F3_XOR:  val = i_a ^ i_b;
                        F3_SR:   val = i_a >> shamt_r;
                        F3_OR:   val = i_a | i_b;
                        F3_AND:  val = i_a & i_b;
                        default: known = 1'b0;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    val = i_a - i_b;
                end else if (f7 == F7_ALT && f3 == F3_SR) begin
                    val = XLEN'($signed(i_a) >>> shamt_r);
                end else begin
                    known = 1'b0;
                end
            end
            OP_IMM: begin
                wr = 1'b1;
                unique case (f3)
                    F3_ADD: val = i_a + imm_i;
                    F3_SLT: val = XLEN'($signed(i_a) < $signed(imm_i));
                    F3_XOR: val = i_a ^ imm_i;
                    F3_OR:  val = i_a | imm_i;
                    F3_AND: val = i_a & imm_i;
                    F3_SLL: begin
                        if (f7 == F7_BASE) val = i_a << shamt_i;
                        else known = 1'b0;
                    end
                    F3_SR: begin
                        if (f7 == F7_BASE) val = i_a >> shamt_i;
                        else if (f7 == F7_ALT) val = XLEN'($signed(i_a) >>> shamt_i);
                        else known = 1'b0;
                    end
                    default: known = 1'b0;
                endcase
            end
            OP_LUI: begin
                wr  = 1'b1;
                val = imm_u;
            end
            OP_AUIPC: begin
                wr  = 1'b1;
                val = i_pc + imm_u;
            end
            OP_JAL: begin
                wr  = 1'b1;
                val = pc_inc;
                npc = i_pc + imm_j;
            end
            OP_JALR: begin
                if (f3 == F3_JALR) begin
                    wr  = 1'b1;
                    val = pc_inc;
                    npc = (i_a + imm_i) & ~XLEN'(1);
                end else begin
                    known = 1'b0;
                end
            end
            OP_BRANCH: begin
                unique case (f3)
                    F3_BEQ:  take = (i_a == i_b);
                    F3_BNE:  take = (i_a != i_b);
                    F3_BLT:  take = ($signed(i_a) < $signed(i_b));
                    F3_BGE:  take = !($signed(i_a) < $signed(i_b));
                    default: known = 1'b0;
                endcase
                if (take) begin
                    npc = i_pc + imm_b;
                end
            end
            OP_LOAD: begin
                if (f3 == F3_WORD) begin
                    wr   = 1'b1;
                    load = 1'b1;
                    addr = i_a + imm_i;
                end else begin
                    known = 1'b0;
                end
            end
            OP_STORE: begin
                if (f3 == F3_WORD) begin
                    mw   = 1'b1;
                    addr = i_a + imm_s;
                end else begin
                    known = 1'b0;
                end
            end
            default: known = 1'b0;
        endcase

        // An unrecognised word leaves everything but the pc alone.
        if (!known) begin
            wr   = 1'b0;
            mw   = 1'b0;
            load = 1'b0;
            addr = '0;
            npc  = pc_inc;
        end
        if (rd == '0) begin
            wr = 1'b0;
        end

        o_res.known = known;
        o_res.wr    = wr;
        o_res.mw    = mw;
        o_res.load  = load && wr;
        o_res.rd    = wr ? rd : '0;
        o_res.val   = (wr && !load) ? val : '0;
        o_res.addr  = addr;
        o_res.npc   = npc;
    end

endmodule

### rtl/rv32i_subset_execute_unit_core.sv
// ----------------------------------------------------------------------------
// rv32i_subset_execute_unit_core
// Executes one RV32I subset instruction per request against a register file
// and a word-addressed data memory, both held in synchronous RAM.
//
//   Channel   Direction  Handshake                    Payload
//   in        input      i_in_valid / o_in_ready      i_instr_word
//   out       output     o_out_valid / i_out_ready    pc, next pc, writes, flags
//   cfg       input      i_cfg_we                     i_cfg_data (start pc)
//
// One request is taken per cycle while the memory is not being cleared; a
// stalled output holds the result register and the execute stage, and a
// request is still taken while the execute stage can move into the output.
// The register file is read at the accepting edge into the execute stage,
// which executes and accesses the data memory as it moves into the result
// register that is offered on the output. Register and pc dependences are
// forwarded, including a load result to the next instruction, so back-to-back
// requests never wait on each other. After reset the memory is cleared, one word
// a cycle. DMEM_WORDS must be a power of two; the block does not enforce it.
// ----------------------------------------------------------------------------
module rv32i_subset_execute_unit_core import rv32x_pkg::*; #(
    parameter int DMEM_WORDS = DMEM_WORDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [XLEN-1:0]  i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [XLEN-1:0]  i_instr_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [XLEN-1:0]  o_pc_of_instr,
    output logic [XLEN-1:0]  o_next_pc,
    output logic             o_reg_written,
    output logic [RF_AW-1:0] o_dest_reg,
    output logic [XLEN-1:0]  o_write_value,
    output logic             o_mem_written,
    output logic [XLEN-1:0]  o_mem_byte_addr,
    output logic             o_known_op
);

    localparam int DMEM_AW = $clog2(DMEM_WORDS);

    // Clearing pass
    logic               r_clr_busy;
    logic [DMEM_AW-1:0] r_clr_idx;

    // Execute stage
    logic               r_s1_v;
    logic [XLEN-1:0]    r_s1_instr;
    logic [XLEN-1:0]    r_pc;

    // Result stage
    logic               r_s2_v;
    logic [XLEN-1:0]    r_s2_pc;
    logic [XLEN-1:0]    r_s2_npc;
    logic               r_s2_wr;
    logic               r_s2_load;
    logic [RF_AW-1:0]   r_s2_rd;
    logic [XLEN-1:0]    r_s2_val;
    logic               r_s2_mw;
    logic [XLEN-1:0]    r_s2_addr;
    logic               r_s2_known;

    logic               in_acc;
    logic               out_acc;
    logic               s2_free;
    logic               s1_move;
    logic [XLEN-1:0]    op_a;
    logic [XLEN-1:0]    op_b;
    t_exec_res          res;
    t_rf_wr             rf_wr;
    t_rf_wr             rf_pend;
    logic [XLEN-1:0]    s2_value;
    logic [DMEM_AW-1:0] dm_idx;
    logic               dm_we;
    logic [DMEM_AW-1:0] dm_waddr;
    logic [XLEN-1:0]    dm_wdata;
    logic               dm_re;
    logic [XLEN-1:0]    dm_rdata;

    assign s2_free    = !r_s2_v || i_out_ready;
    assign o_in_ready = !r_clr_busy && (!r_s1_v || s2_free);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = r_s2_v && i_out_ready;
    assign s1_move    = r_s1_v && s2_free;

    // A load's value comes straight from the data memory's read register,
    // which holds while the result waits.
    assign s2_value = r_s2_load ? dm_rdata : r_s2_val;

    assign rf_pend.v    = r_s2_v && r_s2_wr;
    assign rf_pend.addr = r_s2_rd;
    assign rf_pend.data = s2_value;

    assign rf_wr.v    = out_acc && r_s2_wr;
    assign rf_wr.addr = r_s2_rd;
    assign rf_wr.data = s2_value;

    rv32x_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_re      (in_acc),
        .i_raddr_a (i_instr_word[19:15]),
        .i_raddr_b (i_instr_word[24:20]),
        .i_wr      (rf_wr),
        .i_pend    (rf_pend),
        .o_rdata_a (op_a),
        .o_rdata_b (op_b)
    );

    rv32x_exec u_exec (
        .i_instr (r_s1_instr),
        .i_pc    (r_pc),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_res   (res)
    );

    assign dm_idx   = res.addr[2 +: DMEM_AW];
    assign dm_we    = r_clr_busy || (s1_move && res.mw);
    assign dm_waddr = r_clr_busy ? r_clr_idx : dm_idx;
    assign dm_wdata = r_clr_busy ? '0 : op_b;
    assign dm_re    = s1_move && res.load;

    rv32x_ram #(.WIDTH(XLEN), .DEPTH(DMEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (dm_re),
        .i_raddr (dm_idx),
        .o_rdata (dm_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_pc       <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + DMEM_AW'(1);
                if (r_clr_idx == DMEM_AW'(DMEM_WORDS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (!r_s1_v || s2_free) begin
                r_s1_v <= in_acc;
            end
            if (s2_free) begin
                r_s2_v <= r_s1_v;
            end
            // The execute stage holds its own pc, unless a cfg write sets it.
            if (i_cfg_we) begin
                r_pc <= i_cfg_data;
            end else if (s1_move) begin
                r_pc <= res.npc;
            end
        end
        if (in_acc) begin
            r_s1_instr <= i_instr_word;
        end
        if (s1_move) begin
            r_s2_pc    <= r_pc;
            r_s2_npc   <= res.npc;
            r_s2_wr    <= res.wr;
            r_s2_load  <= res.load;
            r_s2_rd    <= res.rd;
            r_s2_val   <= res.val;
            r_s2_mw    <= res.mw;
            r_s2_addr  <= res.addr;
            r_s2_known <= res.known;
        end
    end

    assign o_out_valid     = r_s2_v;
    assign o_pc_of_instr   = r_s2_pc;
    assign o_next_pc       = r_s2_npc;
    assign o_reg_written   = r_s2_wr;
    assign o_dest_reg      = r_s2_rd;
    assign o_write_value   = s2_value;
    assign o_mem_written   = r_s2_mw;
    assign o_mem_byte_addr = r_s2_addr;
    assign o_known_op      = r_s2_known;

    // The next result in program order starts where the previous one ended.
    a_pc_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_s1_v) |=> (o_pc_of_instr == $past(o_next_pc)))
        else $error("pc of result does not follow previous next pc");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_s1_v && !r_s2_v))
        else $error("instruction in flight during memory clearing");

    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_wr.v |-> (rf_wr.addr != '0))
        else $error("write to register x0");

    a_unknown_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_known_op) |->
            (!o_reg_written && !o_mem_written && o_mem_byte_addr == '0 &&
             o_next_pc == o_pc_of_instr + XLEN'(4)))
        else $error("unrecognised word changed state");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_reg_written) |-> (o_dest_reg == '0 && o_write_value == '0))
        else $error("destination fields set without a register write");

endmodule
